@@ hdl/infix_to_postfix_converter_core_assert.svh @@
// Assertion macros for the converter's port-level checker.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define ITP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off during reset.
`define ITP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define ITP_ASSERT_ALW(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/itp_pkg.sv @@
// Types, character constants and decode functions of the infix to postfix converter.
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [1:0] PREC_POW = 2'd3;
  localparam logic [1:0] PREC_MUL = 2'd2;
  localparam logic [1:0] PREC_ADD = 2'd1;

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_POW    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_ADD    = 3'd4,
    OP_SUB    = 3'd5
  } op_code_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ECHO,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_OPER,
    KIND_FLUSH
  } sym_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAD,
    ST_POP_OP,
    ST_POP_SP
  } conv_state_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       stack_overflow;
  } out_beat_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_cmd_t;

  function automatic sym_kind_t kind_of(input logic [7:0] sym, input logic eoe);
    sym_kind_t k;
    k = KIND_NONE;
    if (eoe) begin
      k = KIND_FLUSH;
    end else if ((sym >= 8'h61 && sym <= 8'h7A) || (sym >= 8'h41 && sym <= 8'h5A) ||
                 (sym >= 8'h30 && sym <= 8'h39) || sym == CH_DOT) begin
      k = KIND_ECHO;
    end else if (sym == CH_LPAREN) begin
      k = KIND_LPAREN;
    end else if (sym == CH_RPAREN) begin
      k = KIND_RPAREN;
    end else if (sym == CH_POW || sym == CH_MUL || sym == CH_DIV ||
                 sym == CH_ADD || sym == CH_SUB) begin
      k = KIND_OPER;
    end
    return k;
  endfunction

  function automatic op_code_t code_of(input logic [7:0] sym);
    op_code_t c;
    case (sym)
      CH_POW:  c = OP_POW;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      default: c = OP_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] char_of(input op_code_t c);
    logic [7:0] ch;
    case (c)
      OP_POW:  ch = CH_POW;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      default: ch = CH_LPAREN;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] prec_of(input op_code_t c);
    logic [1:0] p;
    case (c)
      OP_POW:          p = PREC_POW;
      OP_MUL, OP_DIV:  p = PREC_MUL;
      OP_ADD, OP_SUB:  p = PREC_ADD;
      default:         p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/itp_stack.sv @@
// Operator stack: storage array, fill count and registered top-of-stack read.
module itp_stack #(
  parameter int unsigned DEPTH = itp_pkg::STACK_DEPTH_DEF,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  itp_pkg::stk_cmd_t  cmd,
  output logic [CW-1:0]      count,
  output itp_pkg::op_code_t  top
);
  import itp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  op_code_t        mem [DEPTH];
  logic [CW-1:0]   count_next;
  logic [AW-1:0]   rd_addr;

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  // track the entry that will be on top after this cycle's operation
  assign rd_addr = (count_next == '0) ? '0 : AW'(count_next - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[AW'(count)] <= cmd.code;
    end
    top <= cmd.push ? cmd.code : mem[rd_addr];
  end

endmodule

@@ hdl/infix_to_postfix_converter_core.sv @@
// Top level of the infix to postfix converter: sequencer, output register, stack.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one infix character per beat, or an
//               end-of-expression beat that flushes the operator stack.
//   out channel (out_valid/out_ready/out_data): one postfix character per beat;
//               last_of_run marks the final beat caused by an input beat, and
//               stack_overflow marks an input whose push found the stack full.
// Sequencing:
//   in_ready is high only while the sequencer is idle. An accepted character
//   is decoded into the payload registers, then its leading beat is placed in
//   the output register; each operator popped adds two more beats (operator,
//   then space). Spaces and unknown characters are taken with no output and
//   leave the sequencer idle. The pop loop runs through the stack's registered
//   read port.
// Stall:
//   a full output register that is not taken holds the sequencer in place;
//   no beat is lost or repeated.
// Reset:
//   rst (synchronous, active high) empties the stack, drops any pending beat
//   and returns the sequencer to idle. Stack entries are not cleared.
module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  itp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output itp_pkg::out_beat_t out_data
);
  import itp_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  conv_state_t   state;
  conv_state_t   state_next;
  sym_kind_t     kind;
  logic [7:0]    sym;
  op_code_t      op;

  stk_cmd_t      stk_cmd;
  logic [CW-1:0] count;
  op_code_t      top;

  logic          in_fire;
  sym_kind_t     in_kind;
  logic          can_load;
  logic          load;
  out_beat_t     beat;
  logic          pop_more;
  logic          full;

  assign in_fire  = in_valid & in_ready;
  assign in_kind  = kind_of(in_data.symbol, in_data.end_of_expression);
  assign can_load = ~out_valid | out_ready;
  assign full     = (count >= CW'(STACK_DEPTH));

  // Shared compare unit: decides whether the current top of stack is popped
  // for the item in flight. Used for the first pop and after every pop.
  always_comb begin
    pop_more = 1'b0;
    if (count != '0) begin
      case (kind)
        KIND_FLUSH:  pop_more = 1'b1;
        KIND_RPAREN: pop_more = (top != OP_LPAREN);
        KIND_OPER:   pop_more = (top != OP_LPAREN) && (prec_of(top) >= prec_of(op));
        default:     pop_more = 1'b0;
      endcase
    end
  end

  itp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (stk_cmd),
    .count (count),
    .top   (top)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_kind != KIND_NONE) begin
          state_next = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (can_load) begin
          state_next = pop_more ? ST_POP_OP : ST_IDLE;
        end
      end
      ST_POP_OP: begin
        if (can_load) begin
          state_next = ST_POP_SP;
        end
      end
      ST_POP_SP: begin
        if (can_load) begin
          state_next = pop_more ? ST_POP_OP : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake, output beat and stack commands.
  always_comb begin
    in_ready            = 1'b0;
    load                = 1'b0;
    beat.out_char       = CH_SPACE;
    beat.last_of_run    = 1'b0;
    beat.stack_overflow = 1'b0;
    stk_cmd.push        = 1'b0;
    stk_cmd.pop         = 1'b0;
    stk_cmd.code        = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LEAD: begin
        if (can_load) begin
          load             = 1'b1;
          beat.out_char    = (kind == KIND_ECHO) ? sym : CH_SPACE;
          beat.last_of_run = ~pop_more;
          case (kind)
            KIND_LPAREN: begin
              beat.stack_overflow = full;
              stk_cmd.push        = ~full;
              stk_cmd.code        = OP_LPAREN;
            end
            KIND_RPAREN: begin
              // nothing to pop above the '(': discard it straight away
              stk_cmd.pop = ~pop_more && (count != '0);
            end
            KIND_OPER: begin
              if (!pop_more) begin
                beat.stack_overflow = full;
                stk_cmd.push        = ~full;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_OP: begin
        if (can_load) begin
          load          = 1'b1;
          beat.out_char = char_of(top);
          stk_cmd.pop   = 1'b1;
        end
      end
      ST_POP_SP: begin
        if (can_load) begin
          load             = 1'b1;
          beat.last_of_run = ~pop_more;
          if (!pop_more) begin
            // finish the run: drop the matching '(' or push the new operator
            stk_cmd.pop  = (kind == KIND_RPAREN) && (count != '0);
            stk_cmd.push = (kind == KIND_OPER);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item in flight and the pending beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind <= in_kind;
      sym  <= in_data.symbol;
      op   <= code_of(in_data.symbol);
    end
    if (load) begin
      out_data <= beat;
    end
  end

endmodule

@@ hdl/itp_checker.sv @@
// Port-level checker for the infix to postfix converter, bound to the top level.
`include "infix_to_postfix_converter_core_assert.svh"

module itp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input itp_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input itp_pkg::out_beat_t out_data
);
  import itp_pkg::*;

  logic mid_run;
  logic ovf_beat;
  logic mid_char_ok;

  assign mid_run     = out_valid && !out_data.last_of_run;
  assign ovf_beat    = out_valid && out_data.stack_overflow;
  assign mid_char_ok = out_data.out_char == CH_SPACE || out_data.out_char == CH_LPAREN ||
                       out_data.out_char == CH_POW   || out_data.out_char == CH_MUL ||
                       out_data.out_char == CH_DIV   || out_data.out_char == CH_ADD ||
                       out_data.out_char == CH_SUB;

  // a run still draining keeps the input closed
  `ITP_ASSERT_IMP(a_busy_while_run, clk, rst, mid_run, !in_ready, "input open mid-run")

  // an overflowing push never follows pops, so its flag is on a single-beat run
  `ITP_ASSERT_IMP(a_ovf_single, clk, rst, ovf_beat, out_data.last_of_run, "overflow mid-run")

  // non-final beats carry only spaces and stacked symbols
  `ITP_ASSERT_IMP(a_mid_char, clk, rst, mid_run, mid_char_ok, "bad character inside a run")

  `ITP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")

  // the cycle after any reset cycle shows no pending beat
  `ITP_ASSERT_ALW(a_reset_clear, clk, rst, ##1 !out_valid, "beat pending after reset")

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

@@ tb/sv/infix_to_postfix_converter_core_tb.sv @@
// Self-checking testbench for the infix to postfix converter core.
`timescale 1ns / 100ps

module infix_to_postfix_converter_core_tb;
  import itp_pkg::*;

  localparam int unsigned CONV_DEPTH     = STACK_DEPTH_DEF;
  localparam int          RANDOM_BEATS   = 170;
  localparam int          HOLD_OFF_LEN   = 400;
  localparam int          DRAIN_CYCLES   = 80;
  localparam int          WATCHDOG_LIMIT = 4000;

  // Receiver stall patterns, drawn at random by the receiver pacing block.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Predictor state: operator stack of the converter, kept in step with accepted beats.
  op_code_t    op_stack [CONV_DEPTH];
  int unsigned op_depth = 0;

  // Characters produced by the beat being predicted, and every character still owed.
  logic [7:0] char_run [$];
  out_beat_t  expected_chars [$];

  int errors       = 0;
  int active_beats = 0;
  int burst_left   = 0;
  bit sender_gaps  = 1'b1;
  int hold_req     = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;

  rx_mode_t rx_mode      = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_phase     = 0;

  infix_to_postfix_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_operand_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DOT;
  endfunction

  // Map an operator character to its stack code; zero when it is not an operator.
  function automatic bit decode_operator(input logic [7:0] c, output op_code_t op);
    bit hit;
    hit = 1'b1;
    op  = OP_LPAREN;
    case (c)
      CH_POW:  op = OP_POW;
      CH_MUL:  op = OP_MUL;
      CH_DIV:  op = OP_DIV;
      CH_ADD:  op = OP_ADD;
      CH_SUB:  op = OP_SUB;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic int binding_rank(input op_code_t op);
    int r;
    case (op)
      OP_POW:         r = 3;
      OP_MUL, OP_DIV: r = 2;
      OP_ADD, OP_SUB: r = 1;
      default:        r = 0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_of(input op_code_t op);
    logic [7:0] g;
    case (op)
      OP_POW:  g = CH_POW;
      OP_MUL:  g = CH_MUL;
      OP_DIV:  g = CH_DIV;
      OP_ADD:  g = CH_ADD;
      OP_SUB:  g = CH_SUB;
      default: g = CH_LPAREN;
    endcase
    return g;
  endfunction

  // Pop the top entry and emit it followed by a space.
  function automatic void pop_operator();
    op_depth--;
    char_run.push_back(glyph_of(op_stack[op_depth]));
    char_run.push_back(CH_SPACE);
  endfunction

  // Push unless the stack is full; report whether the push landed.
  function automatic bit push_operator(input op_code_t op);
    if (op_depth >= CONV_DEPTH) begin
      return 1'b0;
    end
    op_stack[op_depth] = op;
    op_depth++;
    return 1'b1;
  endfunction

  // Work out the characters one accepted beat causes and queue them.
  // Spaces and unknown codes fall through every branch and produce nothing.
  function automatic void predict_postfix(input in_beat_t b);
    op_code_t  op;
    bit        dropped;
    out_beat_t ob;
    dropped = 1'b0;
    char_run.delete();
    if (b.end_of_expression) begin
      char_run.push_back(CH_SPACE);
      while (op_depth > 0) pop_operator();
    end else if (is_operand_char(b.symbol)) begin
      char_run.push_back(b.symbol);
    end else if (b.symbol == CH_LPAREN) begin
      char_run.push_back(CH_SPACE);
      dropped = !push_operator(OP_LPAREN);
    end else if (b.symbol == CH_RPAREN) begin
      // Unmatched bracket: the loop simply empties the stack.
      char_run.push_back(CH_SPACE);
      while (op_depth > 0 && op_stack[op_depth - 1] != OP_LPAREN) pop_operator();
      if (op_depth > 0) op_depth--;
    end else if (decode_operator(b.symbol, op)) begin
      // All operators are left-associative, so equal rank pops too.
      char_run.push_back(CH_SPACE);
      while (op_depth > 0 && op_stack[op_depth - 1] != OP_LPAREN &&
             binding_rank(op_stack[op_depth - 1]) >= binding_rank(op)) pop_operator();
      dropped = !push_operator(op);
    end
    foreach (char_run[i]) begin
      ob.out_char       = char_run[i];
      ob.last_of_run    = (i == char_run.size() - 1);
      ob.stack_overflow = dropped;
      expected_chars.push_back(ob);
    end
    if (char_run.size() > 0) active_beats++;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until taken. Bursts of random length with
  // random gaps between them; a gap of zero keeps valid high across beats.
  task automatic send_beat(input logic [7:0] sym, input logic eoe);
    in_beat_t b;
    int       gap;
    b.symbol            = sym;
    b.end_of_expression = eoe;
    if (burst_left == 0) begin
      gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_postfix(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // End of expression; the symbol rides along as don't-care.
  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = 8'h61 + 8'($urandom_range(0, 25));
      1:       c = 8'h41 + 8'($urandom_range(0, 25));
      2:       c = 8'h30 + 8'($urandom_range(0, 9));
      default: c = CH_DOT;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0:       c = CH_POW;
      1:       c = CH_MUL;
      2:       c = CH_DIV;
      3:       c = CH_ADD;
      default: c = CH_SUB;
    endcase
    return c;
  endfunction

  // Expression with random operands, operators and brackets; brackets balance unless one is left open.
  task automatic send_expression(input int terms, input int nest_cap);
    int depth;
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        send_beat(pick_operator(), 1'b0);
        if ($urandom_range(0, 4) == 0) send_beat(CH_SPACE, 1'b0);
      end
      while (depth < nest_cap && $urandom_range(0, 3) == 0) begin
        send_beat(CH_LPAREN, 1'b0);
        depth++;
      end
      repeat ($urandom_range(1, 3)) send_beat(pick_operand(), 1'b0);
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_beat(CH_RPAREN, 1'b0);
        depth--;
      end
    end
    // Now and then leave a bracket open so the flush has to emit it.
    if ($urandom_range(0, 5) != 0) begin
      while (depth > 0) begin
        send_beat(CH_RPAREN, 1'b0);
        depth--;
      end
    end
    send_end();
  endtask

  // Tokens in no particular order: stray brackets, doubled operators.
  task automatic send_broken_sequence();
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 4))
        0:       send_beat(pick_operand(), 1'b0);
        1:       send_beat(pick_operator(), 1'b0);
        2:       send_beat(CH_LPAREN, 1'b0);
        3:       send_beat(CH_RPAREN, 1'b0);
        default: send_beat(CH_SPACE, 1'b0);
      endcase
    end
    if ($urandom_range(0, 1) == 0) send_end();
  endtask

  // Raw bytes over the whole code space, the odd end beat among them.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // Nest close to or past the stack limit, then flush.
  task automatic send_deep_nest();
    repeat ($urandom_range(12, 19)) begin
      send_beat(CH_LPAREN, 1'b0);
      if ($urandom_range(0, 2) == 0) send_beat(pick_operator(), 1'b0);
    end
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver pacing. A hold-off request from a test overrides the pattern.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_phase % 5 < 3);
      endcase
    end
  end

  // Compare each output beat with the oldest character owed.
  always @(posedge clk) begin : check_output
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected output beat: out_char %h", out_data.out_char);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_data.last_of_run);
          errors++;
        end
        if (out_data.stack_overflow !== want.stack_overflow) begin
          $error("stack_overflow: expected %b, got %b",
                 want.stack_overflow, out_data.stack_overflow);
          errors++;
        end
      end
    end
  end

  // Stop the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operand extremes echo; space, zero and top code give nothing.
  task automatic test_echo_and_ignore();
    send_text("azAZ09. ");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
  endtask

  // Equal rank pops (caret included), higher rank stacks up, then flush.
  task automatic test_operator_ranks();
    send_text("^^*/+-^");
    send_end();
  endtask

  // Close bracket on an empty stack, one with no opener beneath operators,
  // a matched pair, and an opener left for the flush.
  task automatic test_brackets();
    send_text(")+*)(^)(");
    send_end();
  endtask

  // Hold the receiver off while the sender keeps offering a nest deep enough
  // to overflow the stack; the block must stall its input and lose nothing.
  task automatic test_full_stack_under_hold_off();
    sender_gaps = 1'b0;
    hold_req    = HOLD_OFF_LEN;
    repeat (CONV_DEPTH + 1) send_beat(CH_LPAREN, 1'b0);
    send_text("+x)");
    send_end();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int goal;
    int pick;
    goal = active_beats + RANDOM_BEATS;
    while (active_beats < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 9) == 0) send_expression($urandom_range(6, 12), 8);
        else send_expression($urandom_range(1, 5), 3);
      end else if (pick < 80) begin
        send_broken_sequence();
      end else if (pick < 92) begin
        send_noise();
      end else begin
        send_deep_nest();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_echo_and_ignore();
    test_operator_ranks();
    test_brackets();
    test_full_stack_under_hold_off();
    test_random_traffic();
    in_valid <= 1'b0;

    // Drain, then allow for a trailing beat that causes no output.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
